>>> hw/rtl/bytebeat_sample_synth_top_defines.svh
// Assertion macros shared by the bytebeat sample synth RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BYTEBEAT_SAMPLE_SYNTH_TOP_DEFINES_SVH
`define BYTEBEAT_SAMPLE_SYNTH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Fixed-delay implication, disabled while reset is asserted
`define BBS_ASSERT_DLY9(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##9 (cons)) else $error(msg);

`endif

>>> hw/rtl/bbs_pkg.sv
// Shared constants, tables and types for the bytebeat sample synth.
// No dependencies; used by bbs_front, bbs_div and the top level.
package bbs_pkg;

  localparam int unsigned TW       = 16;  // sample index width
  localparam int unsigned OW       = 8;   // sample width
  localparam int unsigned NTAP     = 4;   // melody echo taps
  localparam int unsigned DIV_W    = 16;  // divider operand width
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS  = DIV_W / DIV_STAGES;

  localparam logic [7:0]  R_MUL    = 8'd213;
  localparam logic [3:0]  TF_MUL   = 4'd11;
  localparam logic [13:0] ENV_FULL = 14'd8192;
  localparam logic [7:0]  MIDPOINT = 8'h80;

  // Echo tap delays in scaled-time units
  localparam logic [16:0] ECHO_OFS [NTAP] = '{17'd0, 17'd12288, 17'd24576, 17'd36864};

  // Song codes
  localparam logic SONG_MELODY = 1'b0;
  localparam logic SONG_ARP    = 1'b1;

  // Payload leaving the front stages
  typedef struct packed {
    logic       song;
    logic [7:0] mel;   // melody mix, before midpoint flip
    logic [7:0] saw;   // arpeggiator saw
    logic [7:0] bass;  // bass saw
    logic [15:0] word; // rhythm word, never zero
  } front_out_t;

  // Sideband carried alongside the divider
  typedef struct packed {
    logic       song;
    logic [7:0] mel;
    logic [7:0] bass;
  } div_side_t;

  // Melody note for each of the 32 steps, as a base-36 digit
  function automatic logic [4:0] melody_digit(input logic [4:0] idx);
    logic [4:0] d;
    case (idx)
      5'd0, 5'd1, 5'd3, 5'd5:                     d = 5'd9;
      5'd2, 5'd8, 5'd9, 5'd11, 5'd13, 5'd15:     d = 5'd12;
      5'd4, 5'd7:                                d = 5'd14;
      5'd6, 5'd10, 5'd14:                        d = 5'd16;
      5'd12:                                     d = 5'd19;
      5'd16, 5'd17, 5'd19, 5'd21:                d = 5'd7;
      5'd18:                                     d = 5'd11;
      5'd20, 5'd23, 5'd28, 5'd30:                d = 5'd12;
      5'd22:                                     d = 5'd14;
      5'd24, 5'd25, 5'd27, 5'd29:                d = 5'd5;
      5'd26:                                     d = 5'd9;
      5'd31:                                     d = 5'd11;
      default:                                   d = 5'd19;
    endcase
    return d;
  endfunction

  // Note frequency; digits past the table clamp to the top entry
  function automatic logic [7:0] note_freq(input logic [4:0] n);
    logic [7:0] f;
    case (n)
      5'd0:  f = 8'd48;
      5'd1:  f = 8'd51;
      5'd2:  f = 8'd54;
      5'd3:  f = 8'd57;
      5'd4:  f = 8'd60;
      5'd5:  f = 8'd64;
      5'd6:  f = 8'd68;
      5'd7:  f = 8'd72;
      5'd8:  f = 8'd76;
      5'd9:  f = 8'd81;
      5'd10: f = 8'd85;
      5'd11: f = 8'd90;
      5'd12: f = 8'd96;
      5'd13: f = 8'd102;
      5'd14: f = 8'd108;
      5'd15: f = 8'd114;
      5'd16: f = 8'd121;
      5'd17: f = 8'd128;
      5'd18: f = 8'd136;
      default: f = 8'd144;
    endcase
    return f;
  endfunction

  function automatic logic [11:0] arp_pitch(input logic [2:0] idx);
    logic [11:0] p;
    case (idx)
      3'd0:    p = 12'd256;
      3'd1:    p = 12'd512;
      3'd2:    p = 12'd768;
      3'd3:    p = 12'd1024;
      3'd4:    p = 12'd1152;
      3'd5:    p = 12'd1216;
      3'd6:    p = 12'd1536;
      default: p = 12'd2048;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] bass_pitch(input logic [1:0] idx);
    logic [7:0] p;
    case (idx)
      2'd0:    p = 8'd128;
      2'd1:    p = 8'd144;
      2'd2:    p = 8'd152;
      default: p = 8'd171;
    endcase
    return p;
  endfunction

endpackage

>>> hw/rtl/bytebeat_sample_synth_top.sv
// Throughput: one sample per cycle; busy stays low, 4 front stages, 4 divider
// stages of 4 steps each and one output register set the depth.
// Reset (synchronous, rst_n low) clears all valid bits and selects song 0.
// Top level of the bytebeat sample synth; depends on bbs_pkg, bbs_front,
// bbs_div and the assertion macros header.
`include "bytebeat_sample_synth_top_defines.svh"

module bytebeat_sample_synth_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   start,
  output logic                   busy,
  input  logic [bbs_pkg::TW-1:0] in_sample_index,
  output logic                   out_valid,
  output logic [bbs_pkg::OW-1:0] out_sample_value
);

  logic                  song_sel_r;
  logic                  accept;
  logic                  front_valid;
  bbs_pkg::front_out_t   front_data;
  bbs_pkg::div_side_t    div_side_in;
  logic                  div_valid;
  logic                  div_q0;
  bbs_pkg::div_side_t    div_side_out;
  logic                  out_valid_r;
  logic [bbs_pkg::OW-1:0] out_value_r;
  logic                  out_song_r;
  logic [bbs_pkg::OW-1:0] arp_mix;
  logic [bbs_pkg::OW-1:0] value_nxt;

  // The pipeline never stalls, so every start is a transaction
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Song select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_sel_r <= bbs_pkg::SONG_MELODY;
    end else if (cfg_we) begin
      song_sel_r <= cfg_wdata;
    end
  end

  bbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_song   (song_sel_r),
    .in_t      (in_sample_index),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  assign div_side_in.song = front_data.song;
  assign div_side_in.mel  = front_data.mel;
  assign div_side_in.bass = front_data.bass;

  bbs_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (front_valid),
    .in_dividend ({front_data.saw, 8'h00}),
    .in_divisor  (front_data.word),
    .in_side     (div_side_in),
    .out_valid   (div_valid),
    .out_q0      (div_q0),
    .out_side    (div_side_out)
  );

  // Mix the selected song and flip to offset binary
  assign arp_mix   = (div_q0 ? bbs_pkg::MIDPOINT : 8'h00) + {1'b0, div_side_out.bass[7:1]};
  assign value_nxt = ((div_side_out.song == bbs_pkg::SONG_ARP) ? arp_mix : div_side_out.mel)
                     ^ bbs_pkg::MIDPOINT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_valid;
    end
    out_value_r <= value_nxt;
    out_song_r  <= div_side_out.song;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

  `BBS_ASSERT_DLY9(a_start_to_out, accept, out_valid, "accepted sample did not come out after 9 cycles")
  `BBS_ASSERT_IMP(a_out_from_start, out_valid, $past(accept, 9), "result strobe without an accepted sample")
  `BBS_ASSERT_IMP(a_mel_range, out_valid && out_song_r == bbs_pkg::SONG_MELODY, out_sample_value < 8'h71 || out_sample_value >= 8'h80, "melody mix out of range")

endmodule

>>> hw/rtl/bbs_front.sv
// Front pipeline of the bytebeat sample synth: index scaling, table lookups,
// oscillator products and the melody echo mix. Depends on bbs_pkg.
module bbs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_song,
  input  logic [bbs_pkg::TW-1:0] in_t,
  output logic                   out_valid,
  output bbs_pkg::front_out_t    out_data
);

  // Stage 1 registers
  logic                   v1_r;
  logic                   song1_r;
  logic [bbs_pkg::TW-1:0] t1_r;
  logic [15:0]            r1_r;
  logic [19:0]            tf1_r;
  logic [23:0]            r_prod;
  logic [19:0]            tf_nxt;

  // Stage 2 registers
  logic                   v2_r;
  logic                   song2_r;
  logic [bbs_pkg::TW-1:0] t2_r;
  logic                   neg2_r [bbs_pkg::NTAP];
  logic [7:0]             f2_r   [bbs_pkg::NTAP];
  logic [12:0]            pl2_r  [bbs_pkg::NTAP];
  logic [11:0]            p1_2_r;
  logic [7:0]             p2_2_r;
  logic [15:0]            word2_r;
  logic                   neg2_nxt [bbs_pkg::NTAP];
  logic [7:0]             f2_nxt   [bbs_pkg::NTAP];
  logic [12:0]            pl2_nxt  [bbs_pkg::NTAP];
  logic [15:0]            word2_nxt;

  // Stage 3 registers
  logic                   v3_r;
  logic                   song3_r;
  logic                   neg3_r [bbs_pkg::NTAP];
  logic [6:0]             saw3_r [bbs_pkg::NTAP];
  logic [12:0]            pl3_r  [bbs_pkg::NTAP];
  logic [7:0]             asaw3_r;
  logic [7:0]             bass3_r;
  logic [15:0]            word3_r;
  logic [6:0]             saw3_nxt [bbs_pkg::NTAP];
  logic [23:0]            arp_prod;
  logic [23:0]            bass_prod;

  // Stage 4 registers
  logic                   v4_r;
  bbs_pkg::front_out_t    o4_r;
  logic [7:0]             mel_nxt;

  // Scale the index for both songs
  assign r_prod = 24'(in_t) * 24'(bbs_pkg::R_MUL);
  assign tf_nxt = 20'(in_t) * 20'(bbs_pkg::TF_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    song1_r <= in_song;
    t1_r    <= in_t;
    r1_r    <= r_prod[23:8];
    tf1_r   <= tf_nxt;
  end

  // Locate each echo tap and look up its note; derive arpeggio pitches and rhythm
  always_comb begin : s2_logic
    logic [16:0] pos;
    logic [18:0] h;
    logic [15:0] raw;
    pos = '0;
    for (int i = 0; i < bbs_pkg::NTAP; i++) begin
      pos         = {1'b0, r1_r} - bbs_pkg::ECHO_OFS[i];
      neg2_nxt[i] = pos[16];
      pl2_nxt[i]  = pos[12:0];
      f2_nxt[i]   = bbs_pkg::note_freq(bbs_pkg::melody_digit({2'b00, pos[15:13]}));
    end
    h         = tf1_r[19:1];
    raw       = h[15:0] | (16'(h >> 5) ^ 16'(h >> 6));
    word2_nxt = (raw == 16'd0) ? 16'd1 : raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    song2_r <= song1_r;
    t2_r    <= t1_r;
    for (int i = 0; i < bbs_pkg::NTAP; i++) begin
      neg2_r[i] <= neg2_nxt[i];
      f2_r[i]   <= f2_nxt[i];
      pl2_r[i]  <= pl2_nxt[i];
    end
    p1_2_r  <= bbs_pkg::arp_pitch(tf1_r[16:14]);
    p2_2_r  <= bbs_pkg::bass_pitch(tf1_r[19:18]);
    word2_r <= word2_nxt;
  end

  // Run the oscillator products
  always_comb begin : s3_logic
    logic [23:0] prod;
    prod = '0;
    for (int i = 0; i < bbs_pkg::NTAP; i++) begin
      prod        = 24'(t2_r) * 24'(f2_r[i]);
      saw3_nxt[i] = prod[13:7];
    end
  end

  assign arp_prod  = 24'(t2_r) * 24'(p1_2_r);
  assign bass_prod = 24'(t2_r) * 24'(p2_2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    song3_r <= song2_r;
    for (int i = 0; i < bbs_pkg::NTAP; i++) begin
      neg3_r[i] <= neg2_r[i];
      saw3_r[i] <= saw3_nxt[i];
      pl3_r[i]  <= pl2_r[i];
    end
    asaw3_r <= arp_prod[15:8];
    bass3_r <= bass_prod[15:8];
    word3_r <= word2_r;
  end

  // Gate each started tap by the saw-plus-phase carry and mix with halving weights
  always_comb begin : s4_logic
    logic [7:0]  sum;
    logic [13:0] env;
    logic [7:0]  tap;
    sum     = '0;
    env     = '0;
    tap     = '0;
    mel_nxt = '0;
    for (int i = 0; i < bbs_pkg::NTAP; i++) begin
      sum = {1'b0, saw3_r[i]} + {1'b0, pl3_r[i][12:6]};
      env = bbs_pkg::ENV_FULL - {1'b0, pl3_r[i]};
      tap = (sum[7] && !neg3_r[i]) ? env[13:6] : 8'd0;
      mel_nxt = mel_nxt + (tap >> i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    o4_r.song <= song3_r;
    o4_r.mel  <= mel_nxt;
    o4_r.saw  <= asaw3_r;
    o4_r.bass <= bass3_r;
    o4_r.word <= word3_r;
  end

  assign out_valid = v4_r;
  assign out_data  = o4_r;

endmodule

>>> hw/rtl/bbs_div.sv
// Pipelined restoring divider; yields the lowest quotient bit only.
// Depends on bbs_pkg and the assertion macros header.
`include "bytebeat_sample_synth_top_defines.svh"

module bbs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [bbs_pkg::DIV_W-1:0] in_dividend,
  input  logic [bbs_pkg::DIV_W-1:0] in_divisor,
  input  bbs_pkg::div_side_t        in_side,
  output logic                      out_valid,
  output logic                      out_q0,
  output bbs_pkg::div_side_t        out_side
);

  localparam int unsigned LAST = bbs_pkg::DIV_STAGES - 1;

  logic                      vld_r  [bbs_pkg::DIV_STAGES];
  logic [bbs_pkg::DIV_W-1:0] rem_r  [bbs_pkg::DIV_STAGES];
  logic [bbs_pkg::DIV_W-1:0] num_r  [bbs_pkg::DIV_STAGES];
  logic [bbs_pkg::DIV_W-1:0] den_r  [bbs_pkg::DIV_STAGES];
  bbs_pkg::div_side_t        side_r [bbs_pkg::DIV_STAGES];
  logic                      q_last_r;

  for (genvar s = 0; s < bbs_pkg::DIV_STAGES; s++) begin : g_stage
    logic                      vld_in;
    logic [bbs_pkg::DIV_W-1:0] rem_in;
    logic [bbs_pkg::DIV_W-1:0] num_in;
    logic [bbs_pkg::DIV_W-1:0] den_in;
    bbs_pkg::div_side_t        side_in;
    logic [bbs_pkg::DIV_W-1:0] rem_nxt;
    logic                      q_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign num_in  = in_dividend;
      assign den_in  = in_divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign num_in  = num_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Shift in one dividend bit per step, subtract when it fits
    always_comb begin : steps
      logic [bbs_pkg::DIV_W:0] trial;
      trial   = '0;
      rem_nxt = rem_in;
      q_nxt   = 1'b0;
      for (int j = 0; j < bbs_pkg::DIV_STEPS; j++) begin
        trial = {rem_nxt, num_in[bbs_pkg::DIV_W - 1 - s * bbs_pkg::DIV_STEPS - j]};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt = bbs_pkg::DIV_W'(trial - {1'b0, den_in});
          q_nxt   = 1'b1;
        end else begin
          rem_nxt = trial[bbs_pkg::DIV_W-1:0];
          q_nxt   = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
      rem_r[s]  <= rem_nxt;
      num_r[s]  <= num_in;
      den_r[s]  <= den_in;
      side_r[s] <= side_in;
    end

    // Keep the final quotient bit from the last stage
    if (s == LAST) begin : g_q
      always_ff @(posedge clk) begin
        q_last_r <= q_nxt;
      end
    end
  end

  assign out_valid = vld_r[LAST];
  assign out_q0    = q_last_r;
  assign out_side  = side_r[LAST];

  `BBS_ASSERT_IMP(a_rem_below_den, vld_r[LAST], rem_r[LAST] < den_r[LAST], "divider remainder not below divisor")

endmodule

>>> sim/tb_bytebeat_sample_synth_top.sv
// Self-checking testbench for bytebeat_sample_synth_top: drives sample indexes,
// predicts each audio sample for the selected song and compares every output.
// Depends on bbs_pkg and the synth RTL only.
`timescale 1ns / 100ps

module tb_bytebeat_sample_synth_top;

  localparam int unsigned SYNTH_LATENCY = 9;
  localparam int unsigned DRAIN_CYCLES  = SYNTH_LATENCY + 4;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Melody steps as base-36 characters, step 0 in the top byte
  localparam logic [255:0] MELODY_STEPS = "99C9E9GECCGCJCGC77B7C7EC5595C5CB";
  // Note frequencies, entry 0 in the low byte
  localparam logic [159:0] NOTE_STEP = {
    8'd144, 8'd136, 8'd128, 8'd121, 8'd114, 8'd108, 8'd102, 8'd96, 8'd90, 8'd85,
    8'd81, 8'd76, 8'd72, 8'd68, 8'd64, 8'd60, 8'd57, 8'd54, 8'd51, 8'd48};
  localparam logic [95:0] ARP_STEP = {
    12'd2048, 12'd1536, 12'd1216, 12'd1152, 12'd1024, 12'd768, 12'd512, 12'd256};
  localparam logic [31:0] BASS_STEP = {8'd171, 8'd152, 8'd144, 8'd128};

  typedef struct {
    logic [bbs_pkg::TW-1:0] index;
    logic                   song;
    logic [bbs_pkg::OW-1:0] value;
  } sample_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_wdata;
  logic                   start;
  logic                   busy;
  logic [bbs_pkg::TW-1:0] in_sample_index;
  logic                   out_valid;
  logic [bbs_pkg::OW-1:0] out_sample_value;

  sample_t pending_samples[$];
  logic    song_model;
  int      sender_idle_pct;
  int      error_count;
  int      checked_count;

  bytebeat_sample_synth_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_sample_index  (in_sample_index),
    .out_valid        (out_valid),
    .out_sample_value (out_sample_value)
  );

  always #6 clk = ~clk;

  // Level of one echo tap at scaled position pos; zero before the echo starts
  function automatic logic [7:0] echo_level(input logic [bbs_pkg::TW-1:0] t, input int pos);
    logic [15:0] p;
    logic [4:0]  step;
    logic [7:0]  ch;
    logic [7:0]  digit;
    logic [7:0]  freq;
    logic [23:0] phase;
    logic [7:0]  carry_sum;
    logic [13:0] env;
    if (pos < 0) return 8'd0;
    p = 16'(pos);
    step = 5'(p >> 13);
    ch = MELODY_STEPS[255 - 8*step -: 8];
    if (ch <= "9") digit = ch - "0";
    else digit = ch - "A" + 8'd10;
    if (digit > 8'd19) digit = 8'd19;
    freq = NOTE_STEP[8*digit[4:0] +: 8];
    phase = 24'(t) * 24'(freq);
    carry_sum = {1'b0, phase[13:7]} + {1'b0, p[12:6]};
    if (!carry_sum[7]) return 8'd0;
    env = 14'd8192 - {1'b0, p[12:0]};
    return 8'(env >> 6);
  endfunction

  // Expected output sample for index t under the given song
  function automatic logic [bbs_pkg::OW-1:0] synth_sample(input logic song,
                                                          input logic [bbs_pkg::TW-1:0] t);
    logic [23:0] scaled;
    int          r;
    int unsigned mix;
    logic [23:0] tf;
    logic [11:0] lead;
    logic [7:0]  low;
    logic [23:0] lead_phase;
    logic [23:0] bass_phase;
    logic [22:0] h;
    logic [22:0] hx;
    logic [15:0] word;
    logic [15:0] pulse;
    logic [7:0]  main_part;
    logic [7:0]  bass;
    if (song == bbs_pkg::SONG_MELODY) begin
      scaled = 24'(t) * 24'd213;
      r = int'(scaled[23:8]);
      mix = echo_level(t, r) + (echo_level(t, r - 12288) >> 1)
          + (echo_level(t, r - 24576) >> 2) + (echo_level(t, r - 36864) >> 3);
      return 8'(mix) ^ 8'h80;
    end
    tf = 24'(t) * 24'd11;
    lead = ARP_STEP[12*tf[16:14] +: 12];
    low = BASS_STEP[8*tf[19:18] +: 8];
    lead_phase = 24'(t) * 24'(lead);
    bass_phase = 24'(t) * 24'(low);
    h = tf[23:1];
    hx = (h >> 5) ^ (h >> 6);
    word = h[15:0] | hx[15:0];
    // Force a zero rhythm word to one
    if (word == 16'd0) word = 16'd1;
    pulse = {lead_phase[15:8], 8'h00} / word;
    main_part = pulse[0] ? 8'd128 : 8'd0;
    bass = bass_phase[15:8];
    return (main_part + (bass >> 1)) ^ 8'h80;
  endfunction

  // Compare each output sample with the oldest prediction
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid) begin
      if (pending_samples.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected sample %0d with nothing pending", out_sample_value);
      end else begin
        want = pending_samples.pop_front();
        checked_count++;
        if (out_sample_value !== want.value) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch: song %0d index %0d expected %0d got %0d",
                     want.song, want.index, want.value, out_sample_value);
        end
      end
    end
  end

  // Send one sample index and record its prediction at the accepting edge
  task automatic play_index(input logic [bbs_pkg::TW-1:0] t);
    sample_t item;
    @(negedge clk);
    start <= 1'b1;
    in_sample_index <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    item.index = t;
    item.song = song_model;
    item.value = synth_sample(song_model, t);
    pending_samples.push_back(item);
  endtask

  // Drop start for a random gap at the current idle rate
  task automatic sender_gap();
    int n;
    if ($urandom_range(99) < sender_idle_pct) begin
      n = $urandom_range(1, 4);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Hold off until every pending sample has come out
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
  endtask

  // Select a song while the synth is idle
  task automatic write_song(input logic song);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= song;
    @(posedge clk);
    song_model = song;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly uniform indexes, with weight on both ends and echo starts
  function automatic logic [bbs_pkg::TW-1:0] pick_index();
    int unsigned sel;
    int unsigned edge_at;
    sel = $urandom_range(9);
    case (sel)
      0: return 16'($urandom_range(0, 255));
      1: return 16'(65535 - $urandom_range(0, 255));
      2: begin
        case ($urandom_range(2))
          0: edge_at = 14769;
          1: edge_at = 29538;
          default: edge_at = 44307;
        endcase
        return 16'(edge_at + $urandom_range(0, 16) - 8);
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Song 0 straight out of reset, with no register write
  task automatic test_reset_song();
    play_index(16'd0);
    play_index(16'd1);
    play_index(16'hFFFF);
  endtask

  // Melody around the start of each echo, where taps go from zero to live
  task automatic test_melody_edges();
    write_song(bbs_pkg::SONG_MELODY);
    play_index(16'd14768);
    play_index(16'd14769);
    play_index(16'd29537);
    play_index(16'd29538);
    play_index(16'd44306);
    sender_gap();
    play_index(16'd44307);
    play_index(16'h8000);
    play_index(16'h7FFF);
  endtask

  // Arpeggiator, including the zero rhythm word and step boundaries
  task automatic test_arp_edges();
    write_song(bbs_pkg::SONG_ARP);
    play_index(16'd0);
    play_index(16'd1);
    play_index(16'hFFFF);
    play_index(16'h5555);
    play_index(16'hAAAA);
    play_index(16'd1489);
    play_index(16'd1490);
    play_index(16'd23831);
    wait_drained();
  endtask

  // Random indexes under one song, pausing once until drained
  task automatic test_random_run(input logic song, input int idle_pct, input int count);
    sender_idle_pct = idle_pct;
    write_song(song);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      play_index(pick_index());
      sender_gap();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    start = 1'b0;
    in_sample_index = '0;
    song_model = bbs_pkg::SONG_MELODY;
    sender_idle_pct = 6;
    error_count = 0;
    checked_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_song();
    test_melody_edges();
    test_arp_edges();
    test_random_run(bbs_pkg::SONG_MELODY, 6, 67);
    test_random_run(bbs_pkg::SONG_ARP, 6, 67);
    test_random_run(bbs_pkg::SONG_MELODY, 70, 67);
    test_random_run(bbs_pkg::SONG_ARP, 70, 67);
    test_random_run(bbs_pkg::SONG_ARP, 0, 66);
    test_random_run(bbs_pkg::SONG_MELODY, 0, 66);

    // Let the pipeline empty, then watch for stray output
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (pending_samples.size() != 0) error_count++;

    $display("Checked %0d samples over both songs, echo starts, the zero rhythm word,",
             checked_count);
    $display("song switches and three sender pacing modes; %0d errors", error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_front.sv
hw/rtl/bbs_div.sv
hw/rtl/bytebeat_sample_synth_top.sv
sim/tb_bytebeat_sample_synth_top.sv
